@@ src/text_terminal_writer_unit_assert.svh @@
// Assertion macros shared by the text terminal writer RTL.
`ifndef TEXT_TERMINAL_WRITER_UNIT_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TTW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TTW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ttw_pkg.sv @@
// Package with the widths, codes and controller/datapath types of the text terminal writer.
`default_nettype none

package ttw_pkg;

   // Default screen geometry
   localparam int TTW_COLUMNS = 80;
   localparam int TTW_ROWS    = 25;

   // Field widths
   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Character and attribute constants
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_ROW1,
      PTR_LAST_ROW
   } ttw_ptr_load_type;

   typedef enum logic [2:0] {
      MEM_IDLE,
      MEM_BLANK,
      MEM_COPY,
      MEM_CHAR,
      MEM_READ
   } ttw_mem_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_NEWLINE,
      CUR_ADVANCE
   } ttw_cur_op_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             capture;
      ttw_ptr_load_type ptr_load;
      logic             ptr_inc;
      ttw_mem_op_type   mem_op;
      logic             blank_reset;
      ttw_cur_op_type   cur_op;
      logic             set_scrolled;
      logic             rsp_load;
   } ttw_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              is_newline;
      logic              last_row;
      logic              wrap_pending;
      logic              ptr_last;
   } ttw_status_type;

endpackage

`default_nettype wire

@@ src/ttw_req_if.sv @@
// Request channel interface: one command word per handshake.
`default_nettype none

interface ttw_req_if import ttw_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [CHAR_W-1:0] char_code;
   logic [ROW_W-1:0]  read_row;
   logic [COL_W-1:0]  read_col;

   modport source (output valid, output mode, output char_code, output read_row,
                   output read_col, input ready);
   modport sink   (input valid, input mode, input char_code, input read_row,
                   input read_col, output ready);
endinterface

`default_nettype wire

@@ src/ttw_rsp_if.sv @@
// Response channel interface: one result word per handshake.
`default_nettype none

interface ttw_rsp_if import ttw_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  cursor_row;
   logic [COL_W-1:0]  cursor_col;
   logic [CHAR_W-1:0] read_char;
   logic [ATTR_W-1:0] read_attr;
   logic              scrolled;

   modport source (output valid, output cursor_row, output cursor_col, output read_char,
                   output read_attr, output scrolled, input ready);
   modport sink   (input valid, input cursor_row, input cursor_col, input read_char,
                   input read_attr, input scrolled, output ready);
endinterface

`default_nettype wire

@@ src/text_terminal_writer_unit.sv @@
// Top level of the text terminal writer: controller, datapath and channel ports.
//
//   channel   | direction | words
//   ----------+-----------+---------------------------------------------------
//   req_chan  | in        | mode, char_code, read_row, read_col
//   rsp_chan  | out       | cursor_row, cursor_col, read_char, read_attr, scrolled
//   csr_*     | in        | text_attribute write, no read-back
//
// Each word is accepted in idle and then dispatched. A scroll walks the screen memory port,
// copying rows 1 and below up one row and blanking the last row; a wrapped character is
// then written on the new last row.
// A clear screen walks every cell through the one write port of the memory.
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells (2000 by default)
// and accepts no word until it ends; csr writes are taken throughout.
// A stalled result holds in the output register; the next word may be accepted meanwhile.
`default_nettype none

module text_terminal_writer_unit import ttw_pkg::*; #(
   parameter int COLUMNS = TTW_COLUMNS,
   parameter int ROWS    = TTW_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   ttw_req_if.sink           req_chan,
   ttw_rsp_if.source         rsp_chan,
   input  logic              csr_write_enable,
   input  logic [ATTR_W-1:0] csr_write_data
);

   ttw_cmd_type    cmd;
   ttw_status_type status;

   // Sequence the work of each word
   ttw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the screen, cursor and result word
   ttw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_chan.mode),
      .req_char_code    (req_chan.char_code),
      .req_read_row     (req_chan.read_row),
      .req_read_col     (req_chan.read_col),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_cursor_row   (rsp_chan.cursor_row),
      .rsp_cursor_col   (rsp_chan.cursor_col),
      .rsp_read_char    (rsp_chan.read_char),
      .rsp_read_attr    (rsp_chan.read_attr),
      .rsp_scrolled     (rsp_chan.scrolled)
   );

endmodule

`default_nettype wire

@@ src/ttw_dpath.sv @@
// Datapath of the text terminal writer: screen memory, cursor, sweep pointer, result register.
`default_nettype none

`include "text_terminal_writer_unit_assert.svh"

module ttw_dpath import ttw_pkg::*; #(
   parameter int COLUMNS = TTW_COLUMNS,
   parameter int ROWS    = TTW_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  ttw_cmd_type         cmd,
   output ttw_status_type      status,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ROW_W-1:0]    req_read_row,
   input  logic [COL_W-1:0]    req_read_col,
   input  logic                csr_write_enable,
   input  logic [ATTR_W-1:0]   csr_write_data,
   output logic [ROW_W-1:0]    rsp_cursor_row,
   output logic [COL_W-1:0]    rsp_cursor_col,
   output logic [CHAR_W-1:0]   rsp_read_char,
   output logic [ATTR_W-1:0]   rsp_read_attr,
   output logic                rsp_scrolled
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS + 1);

   // Screen store
   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   // Configuration and cursor
   logic [ATTR_W-1:0] attr_ff;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;

   // Latched request word
   logic [MODE_W-1:0] mode_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;

   // Sweep pointer and copy pipeline
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic              copy_pend_ff;
   logic [AW-1:0]     copy_addr_ff;
   logic              scrolled_ff;

   // Memory port signals
   logic              we, re, in_range;
   logic [AW-1:0]     waddr, raddr, cur_addr, rd_addr;
   logic [CELL_W-1:0] wdata;
   logic [ATTR_W-1:0] blank_attr;

   assign cur_addr   = AW'(cur_row_ff) * AW'(COLUMNS) + AW'(cur_col_ff);
   assign rd_addr    = AW'(rrow_ff) * AW'(COLUMNS) + AW'(rcol_ff);
   assign in_range   = (int'(rrow_ff) < ROWS) && (int'(rcol_ff) < COLUMNS);
   assign blank_attr = cmd.blank_reset ? RESET_ATTR : attr_ff;

   // Report status
   assign status.mode         = mode_ff;
   assign status.is_newline   = (char_ff == NEWLINE_CODE);
   assign status.last_row     = (cur_row_ff == RW'(ROWS - 1));
   assign status.wrap_pending = (cur_col_ff >= CW'(COLUMNS));
   assign status.ptr_last     = (ptr_ff == AW'(CELLS - 1));

   // Select the write port: a pending copy write wins
   always_comb begin
      we    = 1'b0;
      waddr = ptr_ff;
      wdata = {blank_attr, SPACE_CODE};
      if (copy_pend_ff) begin
         we    = 1'b1;
         waddr = copy_addr_ff;
         wdata = rdata_ff;
      end else begin
         case (cmd.mem_op)
            MEM_BLANK: begin
               we = 1'b1;
            end
            MEM_CHAR: begin
               we    = 1'b1;
               waddr = cur_addr;
               wdata = {attr_ff, char_ff};
            end
            default: begin
               we = 1'b0;
            end
         endcase
      end
   end

   assign re    = (cmd.mem_op == MEM_COPY) || ((cmd.mem_op == MEM_READ) && in_range);
   assign raddr = (cmd.mem_op == MEM_COPY) ? ptr_ff : rd_addr;

   // Screen memory with registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Next pointer
   always_comb begin
      case (cmd.ptr_load)
         PTR_ZERO:     ptr_in = '0;
         PTR_ROW1:     ptr_in = AW'(COLUMNS);
         PTR_LAST_ROW: ptr_in = AW'((ROWS - 1) * COLUMNS);
         default:      ptr_in = cmd.ptr_inc ? ptr_ff + AW'(1) : ptr_ff;
      endcase
   end

   // Next cursor
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      case (cmd.cur_op)
         CUR_NEWLINE: begin
            cur_col_in = '0;
            if (!status.last_row) begin
               cur_row_in = cur_row_ff + RW'(1);
            end
         end
         CUR_ADVANCE: begin
            cur_col_in = cur_col_ff + CW'(1);
         end
         default: begin
            cur_col_in = cur_col_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= RESET_ATTR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         ptr_ff       <= '0;
         copy_pend_ff <= 1'b0;
         scrolled_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         ptr_ff       <= ptr_in;
         copy_pend_ff <= (cmd.mem_op == MEM_COPY);
         if (cmd.capture) begin
            scrolled_ff <= 1'b0;
         end else if (cmd.set_scrolled) begin
            scrolled_ff <= 1'b1;
         end
      end
   end

   // Payload registers: request latch, copy target, result word
   always_ff @(posedge clock) begin
      copy_addr_ff <= ptr_ff - AW'(COLUMNS);
      if (cmd.capture) begin
         mode_ff <= req_mode;
         char_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
      if (cmd.rsp_load) begin
         rsp_cursor_row <= ROW_W'(cur_row_ff);
         rsp_cursor_col <= COL_W'(cur_col_ff);
         rsp_scrolled   <= scrolled_ff;
         if ((mode_ff == MODE_READ) && in_range) begin
            rsp_read_char <= rdata_ff[CHAR_W-1:0];
            rsp_read_attr <= rdata_ff[CELL_W-1:CHAR_W];
         end else begin
            rsp_read_char <= '0;
            rsp_read_attr <= '0;
         end
      end
   end

   `TTW_ASSERT_IMP(a_no_write_clash, clock, reset, copy_pend_ff, (cmd.mem_op != MEM_BLANK) && (cmd.mem_op != MEM_CHAR), "copy write collides with another write")
   `TTW_ASSERT_IMP(a_char_in_row, clock, reset, cmd.mem_op == MEM_CHAR, !status.wrap_pending, "character written past the row end")
   `TTW_ASSERT_IMP(a_col_bound, clock, reset, 1'b1, cur_col_ff <= CW'(COLUMNS), "cursor column beyond the wrap position")

endmodule

`default_nettype wire

@@ src/ttw_ctrl.sv @@
// Controller of the text terminal writer: sequences writes, scrolls, clears and reads.
`default_nettype none

`include "text_terminal_writer_unit_assert.svh"

module ttw_ctrl import ttw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ttw_status_type status,
   output ttw_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_COPY,
      S_GAP,
      S_BLANK,
      S_CHAR,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      then_char_ff, then_char_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      then_char_in = then_char_ff;
      cmd          = '0;
      case (state_ff)
         S_INIT: begin
            // Clear the screen to reset blanks
            cmd.mem_op      = MEM_BLANK;
            cmd.blank_reset = 1'b1;
            cmd.ptr_inc     = 1'b1;
            if (status.ptr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.mode)
               MODE_PUT: begin
                  if (status.is_newline || status.wrap_pending) begin
                     then_char_in = !status.is_newline;
                     if (status.last_row) begin
                        cmd.ptr_load = PTR_ROW1;
                        state_in     = S_COPY;
                     end else begin
                        cmd.cur_op = CUR_NEWLINE;
                        state_in   = status.is_newline ? S_DONE : S_CHAR;
                     end
                  end else begin
                     cmd.mem_op = MEM_CHAR;
                     cmd.cur_op = CUR_ADVANCE;
                     state_in   = S_DONE;
                  end
               end
               MODE_CLEAR: begin
                  cmd.ptr_load = PTR_ZERO;
                  state_in     = S_CLEAR;
               end
               MODE_READ: begin
                  cmd.mem_op = MEM_READ;
                  state_in   = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_COPY: begin
            // Move rows up one cell at a time
            cmd.mem_op  = MEM_COPY;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_last) begin
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            // Let the last copy write drain
            cmd.ptr_load = PTR_LAST_ROW;
            state_in     = S_BLANK;
         end
         S_BLANK: begin
            cmd.mem_op  = MEM_BLANK;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_last) begin
               cmd.cur_op       = CUR_NEWLINE;
               cmd.set_scrolled = 1'b1;
               state_in         = then_char_ff ? S_CHAR : S_DONE;
            end
         end
         S_CHAR: begin
            cmd.mem_op = MEM_CHAR;
            cmd.cur_op = CUR_ADVANCE;
            state_in   = S_DONE;
         end
         S_CLEAR: begin
            cmd.mem_op  = MEM_BLANK;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the result register is free
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.rsp_load;

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         then_char_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         then_char_ff <= then_char_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TTW_ASSERT_NXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second word accepted while one is at work")
   `TTW_ASSERT_NXT(a_rsp_loaded, clock, reset, cmd.rsp_load, rsp_valid_ff, "result loaded but not shown")
   `TTW_ASSERT_IMP(a_no_rsp_in_init, clock, reset, state_ff == S_INIT, !rsp_valid_ff, "result shown during the clearing pass")

endmodule

`default_nettype wire

@@ tb/tb_text_terminal_writer_unit.sv @@
// Testbench for the text terminal writer: directed and random words checked against a screen model.
`timescale 1ns / 100ps

module tb_text_terminal_writer_unit;
   import ttw_pkg::*;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int SCREEN_CELLS  = TTW_ROWS * TTW_COLUMNS;
   localparam int SETTLE_CYCLES = SCREEN_CELLS + 16;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_WORDS   = 210;
   localparam int HOLD_CYCLES   = 300;

   // The one mode code with no operation behind it
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } terminal_cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attr;
      logic              scrolled;
   } terminal_status_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;

   ttw_req_if req_bus ();
   ttw_rsp_if rsp_bus ();

   // Screen model: attribute in the high byte, character in the low byte
   logic [CELL_W-1:0] screen_image [TTW_ROWS][TTW_COLUMNS];
   logic [ROW_W-1:0]  cursor_row_q;
   logic [COL_W-1:0]  cursor_col_q;
   logic [ATTR_W-1:0] attribute_q;

   terminal_status_type expected_status [$];
   int                  mismatch_count = 0;
   bit                  idle_enable    = 1'b1;
   int                  rsp_hold_left  = 0;

   text_terminal_writer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idle_enable || pick < 50) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   // Fill one row with spaces in the current attribute.
   function automatic void blank_row(input int row);
      for (int col = 0; col < TTW_COLUMNS; col++) begin
         screen_image[row][col] = {attribute_q, SPACE_CODE};
      end
   endfunction

   // Go to column 0 of the next row; scroll up when already on the last row.
   function automatic logic line_feed();
      cursor_col_q = '0;
      if (cursor_row_q < TTW_ROWS - 1) begin
         cursor_row_q++;
         return 1'b0;
      end
      for (int row = 1; row < TTW_ROWS; row++) begin
         for (int col = 0; col < TTW_COLUMNS; col++) begin
            screen_image[row - 1][col] = screen_image[row][col];
         end
      end
      blank_row(TTW_ROWS - 1);
      return 1'b1;
   endfunction

   // Apply one command word to the screen model and return the status it reports.
   function automatic terminal_status_type predict_status(input terminal_cmd_type cmd);
      terminal_status_type status;
      status = '0;
      case (cmd.mode)
         MODE_PUT: begin
            if (cmd.char_code == NEWLINE_CODE) begin
               status.scrolled = line_feed();
            end else begin
               // a full row wraps before the character lands
               if (cursor_col_q >= TTW_COLUMNS) begin
                  status.scrolled = line_feed();
               end
               screen_image[cursor_row_q][cursor_col_q] = {attribute_q, cmd.char_code};
               cursor_col_q++;
            end
         end
         MODE_CLEAR: begin
            for (int row = 0; row < TTW_ROWS; row++) begin
               blank_row(row);
            end
         end
         MODE_READ: begin
            // out-of-range reads return zeros
            if (cmd.read_row < TTW_ROWS && cmd.read_col < TTW_COLUMNS) begin
               {status.read_attr, status.read_char} = screen_image[cmd.read_row][cmd.read_col];
            end
         end
         default: begin
         end
      endcase
      status.cursor_row = cursor_row_q;
      status.cursor_col = cursor_col_q;
      return status;
   endfunction

   // Mostly characters and reads, a few newlines, clears and unused-mode words.
   function automatic terminal_cmd_type random_command();
      terminal_cmd_type cmd;
      int               pick;
      pick          = $urandom_range(0, 999);
      cmd.mode      = MODE_PUT;
      cmd.char_code = CHAR_W'($urandom_range(0, 255));
      cmd.read_row  = ROW_W'($urandom_range(0, 31));
      cmd.read_col  = COL_W'($urandom_range(0, 127));
      if (pick < 30) begin
         cmd.char_code = NEWLINE_CODE;
      end else if (pick < 120) begin
         cmd.mode     = MODE_READ;
         cmd.read_row = cursor_row_q;
         cmd.read_col = COL_W'($urandom_range(0, TTW_COLUMNS - 1));
      end else if (pick < 170) begin
         cmd.mode     = MODE_READ;
         cmd.read_row = ROW_W'($urandom_range(0, TTW_ROWS - 1));
         cmd.read_col = COL_W'($urandom_range(0, TTW_COLUMNS - 1));
      end else if (pick < 200) begin
         cmd.mode = MODE_READ;
      end else if (pick < 215) begin
         cmd.mode = MODE_CLEAR;
      end else if (pick < 240) begin
         cmd.mode = MODE_UNUSED;
      end
      return cmd;
   endfunction

   // Offer one word after a random gap; predict its status once it is taken.
   task automatic send_word(input terminal_cmd_type cmd);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= cmd.mode;
      req_bus.char_code <= cmd.char_code;
      req_bus.read_row  <= cmd.read_row;
      req_bus.read_col  <= cmd.read_col;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_status.push_back(predict_status(cmd));
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      terminal_cmd_type cmd;
      cmd.mode      = MODE_PUT;
      cmd.char_code = ch;
      cmd.read_row  = ROW_W'($urandom_range(0, 31));
      cmd.read_col  = COL_W'($urandom_range(0, 127));
      send_word(cmd);
   endtask

   task automatic read_cell(input int row, input int col);
      terminal_cmd_type cmd;
      cmd.mode      = MODE_READ;
      cmd.char_code = CHAR_W'($urandom_range(0, 255));
      cmd.read_row  = ROW_W'(row);
      cmd.read_col  = COL_W'(col);
      send_word(cmd);
   endtask

   // Drop valid, wait for every pending status, then let any screen walk finish.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      attribute_q = value;
   endtask

   task automatic compare_field(input string field_name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // Corners of the screen after the clearing pass
   task automatic test_reset_contents();
      read_cell(0, 0);
      read_cell(0, TTW_COLUMNS - 1);
      read_cell(TTW_ROWS - 1, 0);
      read_cell(TTW_ROWS - 1, TTW_COLUMNS - 1);
   endtask

   // Character extremes, a newline, out-of-range reads and the unused mode
   task automatic test_put_extremes();
      terminal_cmd_type cmd;
      put_char(8'h00);
      put_char(8'hFF);
      put_char(SPACE_CODE);
      read_cell(0, 0);
      read_cell(0, 1);
      put_char(NEWLINE_CODE);
      read_cell(TTW_ROWS, 0);
      read_cell(0, TTW_COLUMNS);
      read_cell(31, 127);
      cmd.mode      = MODE_UNUSED;
      cmd.char_code = 8'hFF;
      cmd.read_row  = 5'd31;
      cmd.read_col  = 7'd127;
      send_word(cmd);
   endtask

   // Clear with attribute zero and check that old text is gone
   task automatic test_clear_screen();
      terminal_cmd_type cmd;
      write_attribute(8'h00);
      put_char(8'h41);
      read_cell(1, 0);
      cmd.mode      = MODE_CLEAR;
      cmd.char_code = NEWLINE_CODE;
      cmd.read_row  = 5'd31;
      cmd.read_col  = 7'd127;
      send_word(cmd);
      read_cell(1, 0);
      read_cell(0, 0);
      read_cell(TTW_ROWS - 1, TTW_COLUMNS - 1);
   endtask

   // Lines of random text past the bottom row: wraps, scrolls and reads of moved rows
   task automatic test_wrap_and_scroll();
      int                len;
      logic [CHAR_W-1:0] ch;
      write_attribute(8'hFF);
      for (int line = 0; line < TTW_ROWS + 4; line++) begin
         if (line % 6 == 2) begin
            len = TTW_COLUMNS + ((line == 8) ? 0 : $urandom_range(0, 8));
         end else begin
            len = $urandom_range(0, 16);
         end
         repeat (len) begin
            ch = CHAR_W'($urandom_range(0, 255));
            if (ch == NEWLINE_CODE) begin
               ch = SPACE_CODE;
            end
            put_char(ch);
         end
         put_char(NEWLINE_CODE);
         read_cell((cursor_row_q == 0) ? 0 : int'(cursor_row_q) - 1, $urandom_range(0, 15));
         read_cell($urandom_range(0, TTW_ROWS - 1), $urandom_range(0, TTW_COLUMNS - 1));
      end
   endtask

   // Hold the result side for a long stretch while words keep coming
   task automatic test_back_pressure();
      idle_enable   = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      repeat (12) send_word(random_command());
      idle_enable = 1'b1;
   endtask

   // Random phases, each under a fresh attribute; one phase runs without gaps
   task automatic test_random_traffic();
      terminal_cmd_type cmd;
      int               counted;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_attribute(ATTR_W'($urandom_range(0, 255)));
         idle_enable = (phase != 1);
         counted     = 0;
         while (counted < PHASE_WORDS) begin
            cmd = random_command();
            send_word(cmd);
            if (cmd.mode != MODE_UNUSED) begin
               counted++;
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   // Drive result ready: random stalls, plus the long hold when one is asked for
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = draw_gap();
         end
      end
   end

   // Check each accepted result word against the oldest prediction
   always @(posedge clock) begin : status_check
      terminal_status_type want;
      terminal_status_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.cursor_row = rsp_bus.cursor_row;
         got.cursor_col = rsp_bus.cursor_col;
         got.read_char  = rsp_bus.read_char;
         got.read_attr  = rsp_bus.read_attr;
         got.scrolled   = rsp_bus.scrolled;
         if (expected_status.size() == 0) begin
            $display("%0t: result word with none expected, expected none, actual %h",
                     $time, got);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
            compare_field("read_char", 16'(want.read_char), 16'(got.read_char));
            compare_field("read_attr", 16'(want.read_attr), 16'(got.read_attr));
            compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
         end
      end
   end

   initial begin : test_sequence
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = MODE_PUT;
      req_bus.char_code = '0;
      req_bus.read_row  = '0;
      req_bus.read_col  = '0;
      // reset state: spaces in the reset attribute, cursor home
      for (int row = 0; row < TTW_ROWS; row++) begin
         for (int col = 0; col < TTW_COLUMNS; col++) begin
            screen_image[row][col] = {RESET_ATTR, SPACE_CODE};
         end
      end
      cursor_row_q = '0;
      cursor_col_q = '0;
      attribute_q  = RESET_ATTR;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_put_extremes();
      test_clear_screen();
      test_wrap_and_scroll();
      test_back_pressure();
      test_random_traffic();
      settle_block();

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // End a hung run
   initial begin : watchdog
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/ttw_pkg.sv
src/ttw_req_if.sv
src/ttw_rsp_if.sv
src/ttw_dpath.sv
src/ttw_ctrl.sv
src/text_terminal_writer_unit.sv
tb/tb_text_terminal_writer_unit.sv
